// ----- src/pcfb_pkg.sv -----
// Package for the palette color fade blend block.
// Holds beat payload types, configuration types, register indexes and easing curves.
// Depends on nothing.
package pcfb_pkg;

    localparam int unsigned CHAN_W    = 5;
    localparam int unsigned COLOR_W   = 15;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned ENTRY_W   = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 6;
    localparam int unsigned WGT_W     = 6;

    localparam logic [WGT_W-1:0]  FULL_WEIGHT = 6'd32;
    localparam logic [WGT_W-1:0]  HUE_OFFSET  = 6'd4;
    localparam logic [CHAN_W-1:0] CHAN_MAX    = 5'h1F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_SEL   = 3'd0,
        REG_TARGET_RED   = 3'd1,
        REG_TARGET_GREEN = 3'd2,
        REG_TARGET_BLUE  = 3'd3,
        REG_SPEED_MASK   = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        STYLE_WHITE  = 2'd0,
        STYLE_BLACK  = 2'd1,
        STYLE_CUSTOM = 2'd2,
        STYLE_DARK   = 2'd3
    } t_style;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry_index;
        logic [IDX_W-1:0]   fade_index;
        logic [COLOR_W-1:0] color_in;
    } t_pix_in;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry_out;
        logic [COLOR_W-1:0] faded_color;
    } t_pix_out;

    typedef struct packed {
        t_style            target_sel;
        logic [CHAN_W-1:0] target_red;
        logic [CHAN_W-1:0] target_green;
        logic [CHAN_W-1:0] target_blue;
        logic [5:0]        speed_mask;
    } t_cfg;

    function automatic logic [WGT_W-1:0] f_ease8(input logic [3:0] idx);
        logic [WGT_W-1:0] w;
        case (idx)
            4'd0:    w = 6'd0;
            4'd1:    w = 6'd2;
            4'd2:    w = 6'd5;
            4'd3:    w = 6'd10;
            4'd4:    w = 6'd16;
            4'd5:    w = 6'd22;
            4'd6:    w = 6'd27;
            4'd7:    w = 6'd30;
            default: w = 6'd32;
        endcase
        return w;
    endfunction

    function automatic logic [WGT_W-1:0] f_ease16(input logic [4:0] idx);
        logic [WGT_W-1:0] w;
        case (idx)
            5'd0:    w = 6'd0;
            5'd1:    w = 6'd1;
            5'd2:    w = 6'd2;
            5'd3:    w = 6'd4;
            5'd4:    w = 6'd6;
            5'd5:    w = 6'd9;
            5'd6:    w = 6'd12;
            5'd7:    w = 6'd14;
            5'd8:    w = 6'd16;
            5'd9:    w = 6'd18;
            5'd10:   w = 6'd20;
            5'd11:   w = 6'd23;
            5'd12:   w = 6'd26;
            5'd13:   w = 6'd28;
            5'd14:   w = 6'd30;
            5'd15:   w = 6'd31;
            default: w = 6'd32;
        endcase
        return w;
    endfunction

endpackage

// ----- src/pcfb_cfg.sv -----
// Configuration registers of the palette color fade blend block.
// Decodes the plain write port into one register set; uses pcfb_pkg.
module pcfb_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pcfb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pcfb_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    output pcfb_pkg::t_cfg                    o_cfg
);

    pcfb_pkg::t_cfg r_cfg;
    pcfb_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (pcfb_pkg::t_reg_idx'(i_cfg_idx))
                pcfb_pkg::REG_TARGET_SEL:   n_cfg.target_sel   =
                                                pcfb_pkg::t_style'(i_cfg_data[1:0]);
                pcfb_pkg::REG_TARGET_RED:   n_cfg.target_red   = i_cfg_data[4:0];
                pcfb_pkg::REG_TARGET_GREEN: n_cfg.target_green = i_cfg_data[4:0];
                pcfb_pkg::REG_TARGET_BLUE:  n_cfg.target_blue  = i_cfg_data[4:0];
                pcfb_pkg::REG_SPEED_MASK:   n_cfg.speed_mask   = i_cfg_data;
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_sel   <= pcfb_pkg::STYLE_WHITE;
            r_cfg.target_red   <= '0;
            r_cfg.target_green <= '0;
            r_cfg.target_blue  <= '0;
            r_cfg.speed_mask   <= 6'd3;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/pcfb_blend.sv -----
// Combinational fade datapath: easing curve, hue offset and per-channel blend.
// Sits between the input and result registers of the top level; uses pcfb_pkg.
module pcfb_blend #(
    parameter int unsigned PALETTE_ENTRIES = 64
) (
    input  pcfb_pkg::t_cfg     i_cfg,
    input  pcfb_pkg::t_pix_in  i_pix,
    output pcfb_pkg::t_pix_out o_pix
);

    localparam int unsigned NUM_CODES = 1 << pcfb_pkg::ENTRY_W;

    logic [pcfb_pkg::ENTRY_W-1:0] entry_wrap [NUM_CODES];

    for (genvar g = 0; g < NUM_CODES; g++) begin : g_wrap
        localparam int unsigned WRAPPED = g % PALETTE_ENTRIES;
        assign entry_wrap[g] = pcfb_pkg::ENTRY_W'(WRAPPED);
    end

    function automatic logic [pcfb_pkg::CHAN_W-1:0] f_mix(
        input logic [pcfb_pkg::CHAN_W-1:0] c,
        input logic [pcfb_pkg::CHAN_W-1:0] t,
        input logic [pcfb_pkg::WGT_W-1:0]  w
    );
        logic [10:0] acc;
        acc = 11'(c) * 11'(pcfb_pkg::FULL_WEIGHT - w) + 11'(t) * 11'(w);
        return acc[9:5];
    endfunction

    logic [pcfb_pkg::IDX_W-1:0]  idx;
    logic [pcfb_pkg::WGT_W-1:0]  w;
    logic [pcfb_pkg::WGT_W-1:0]  w_hue;
    logic [pcfb_pkg::WGT_W-1:0]  wrb;
    logic [pcfb_pkg::WGT_W-1:0]  wg;
    logic [pcfb_pkg::CHAN_W-1:0] tr, tg, tb;
    logic [pcfb_pkg::CHAN_W-1:0] cr, cg, cb;
    logic [pcfb_pkg::COLOR_W-1:0] color;

    assign idx = i_pix.fade_index;
    assign cr  = i_pix.color_in[4:0];
    assign cg  = i_pix.color_in[9:5];
    assign cb  = i_pix.color_in[14:10];

    always_comb begin
        if (i_cfg.speed_mask <= 6'd1) begin
            w = pcfb_pkg::f_ease8((idx > 6'd8) ? 4'd8 : idx[3:0]);
        end else if (i_cfg.speed_mask <= 6'd7) begin
            w = pcfb_pkg::f_ease16((idx > 6'd16) ? 5'd16 : idx[4:0]);
        end else begin
            w = (idx > pcfb_pkg::FULL_WEIGHT) ? pcfb_pkg::FULL_WEIGHT : idx;
        end
    end

    always_comb begin
        w_hue = w + pcfb_pkg::HUE_OFFSET;
        if (w_hue > pcfb_pkg::FULL_WEIGHT) begin
            w_hue = pcfb_pkg::FULL_WEIGHT;
        end
        wrb = w;
        wg  = w;
        tr  = '0;
        tg  = '0;
        tb  = '0;
        unique case (i_cfg.target_sel)
            pcfb_pkg::STYLE_WHITE: begin
                tr  = pcfb_pkg::CHAN_MAX;
                tg  = pcfb_pkg::CHAN_MAX;
                tb  = pcfb_pkg::CHAN_MAX;
                wrb = w_hue;
            end
            pcfb_pkg::STYLE_BLACK: begin
                wg = w_hue;
            end
            pcfb_pkg::STYLE_CUSTOM: begin
                tr = i_cfg.target_red;
                tg = i_cfg.target_green;
                tb = i_cfg.target_blue;
            end
            default: begin
                wg = w;
            end
        endcase
    end

    always_comb begin
        if (w == '0) begin
            color = i_pix.color_in;
        end else if (w >= pcfb_pkg::FULL_WEIGHT) begin
            color = {tb, tg, tr};
        end else begin
            color = {f_mix(cb, tb, wrb), f_mix(cg, tg, wg), f_mix(cr, tr, wrb)};
        end
    end

    assign o_pix.faded_color = color;
    assign o_pix.entry_out   = entry_wrap[i_pix.entry_index];

endmodule

// ----- src/palette_color_fade_blend.sv -----
// Top level of the palette color fade blend block.
// Input register, pcfb_blend datapath, result register; pcfb_cfg holds settings.
//
//  beat       dir  handshake                 payload
//  input      in   i_in_valid / o_in_stall   i_in_data  (pcfb_pkg::t_pix_in)
//  result     out  o_out_valid / i_out_stall o_out_data (pcfb_pkg::t_pix_out)
//  config     in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One beat per cycle sustained while the result side does not stall; each result passes
// through the input register, one blend pass and the result register.
// Synchronous active-low reset clears valid flags and loads register reset values.
// A stall on the result side holds both stages; o_in_stall rises only when both are full.
module palette_color_fade_blend #(
    parameter int unsigned PALETTE_ENTRIES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pcfb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pcfb_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pcfb_pkg::t_pix_in              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pcfb_pkg::t_pix_out             o_out_data
);

    pcfb_pkg::t_cfg     cfg;
    pcfb_pkg::t_pix_out blend_pix;

    logic               r_in_valid;
    pcfb_pkg::t_pix_in  r_in_data;
    logic               r_out_valid;
    pcfb_pkg::t_pix_out r_out_data;
    logic               out_adv;
    logic               in_adv;

    pcfb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pcfb_blend #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_blend (
        .i_cfg (cfg),
        .i_pix (r_in_data),
        .o_pix (blend_pix)
    );

    assign out_adv    = !r_out_valid || !i_out_stall;
    assign in_adv     = !r_in_valid || out_adv;
    assign o_in_stall = !in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (out_adv && r_in_valid) begin
            r_out_data <= blend_pix;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- dv/tb_palette_color_fade_blend.sv -----
// Testbench for palette_color_fade_blend: directed table, then random phases per setting.
// Checks every result beat against an in-bench fade predictor; depends on pcfb_pkg.
`timescale 1ns / 100ps

module tb_palette_color_fade_blend;

    localparam int PAL_ENTRIES = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES = 64;
    localparam int PHASES = 8;
    localparam int PHASE_BEATS = 180;
    localparam logic [pcfb_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [pcfb_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic ROW_CFG = 1'b1;
    localparam logic ROW_PIX = 1'b0;
    localparam int DIR_ROWS = 35;

    typedef struct packed {
        logic                           is_cfg;
        logic [pcfb_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [pcfb_pkg::CFG_DAT_W-1:0] reg_val;
        logic [pcfb_pkg::COLOR_W-1:0]   color;
        logic [pcfb_pkg::IDX_W-1:0]     fidx;
        logic [pcfb_pkg::ENTRY_W-1:0]   entry;
        logic                           known;
        logic [pcfb_pkg::COLOR_W-1:0]   known_color;
    } t_dir_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [pcfb_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [pcfb_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    pcfb_pkg::t_pix_in              i_in_data = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    pcfb_pkg::t_pix_out             o_out_data;

    pcfb_pkg::t_cfg     fade_cfg;
    pcfb_pkg::t_pix_out fade_q[$];
    pcfb_pkg::t_pix_out want_out;
    int                 err_count = 0;
    int                 quiet_cycles = 0;
    bit                 hold_req = 1'b0;

    int ease8_tbl [9] = '{0, 2, 5, 10, 16, 22, 27, 30, 32};
    int ease16_tbl [17] = '{0, 1, 2, 4, 6, 9, 12, 14, 16, 18, 20, 23, 26, 28, 30, 31, 32};

    t_dir_row dir_table [DIR_ROWS] = '{
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h1234, 6'd0,  6'd0,  1'b1, 15'h1234},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h0000, 6'd16, 6'd63, 1'b1, 15'h7FFF},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h7FFF, 6'd63, 6'd1,  1'b1, 15'h7FFF},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h4210, 6'd5,  6'd2,  1'b0, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h7FFF, 6'd15, 6'd3,  1'b0, 15'h0000},
        '{ROW_CFG, pcfb_pkg::REG_TARGET_SEL,   6'h3D, 15'h0000, 6'd0,  6'd0,  1'b0, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h7FFF, 6'd16, 6'd4,  1'b1, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h7FFF, 6'd8,  6'd5,  1'b0, 15'h0000},
        '{ROW_CFG, pcfb_pkg::REG_SPEED_MASK,   6'h00, 15'h0000, 6'd0,  6'd0,  1'b0, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h5555, 6'd8,  6'd6,  1'b1, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h2AAA, 6'd4,  6'd7,  1'b0, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h3FFF, 6'd9,  6'd8,  1'b1, 15'h0000},
        '{ROW_CFG, pcfb_pkg::REG_TARGET_SEL,   6'h3E, 15'h0000, 6'd0,  6'd0,  1'b0, 15'h0000},
        '{ROW_CFG, pcfb_pkg::REG_TARGET_RED,   6'h3F, 15'h0000, 6'd0,  6'd0,  1'b0, 15'h0000},
        '{ROW_CFG, pcfb_pkg::REG_TARGET_GREEN, 6'h20, 15'h0000, 6'd0,  6'd0,  1'b0, 15'h0000},
        '{ROW_CFG, pcfb_pkg::REG_TARGET_BLUE,  6'h15, 15'h0000, 6'd0,  6'd0,  1'b0, 15'h0000},
        '{ROW_CFG, pcfb_pkg::REG_SPEED_MASK,   6'h3F, 15'h0000, 6'd0,  6'd0,  1'b0, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h0000, 6'd32, 6'd9,  1'b1, 15'h541F},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h7FFF, 6'd31, 6'd10, 1'b0, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h0C63, 6'd1,  6'd11, 1'b0, 15'h0000},
        '{ROW_CFG, REG_SPARE_HI,               6'h3F, 15'h0000, 6'd0,  6'd0,  1'b0, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h0000, 6'd63, 6'd12, 1'b1, 15'h541F},
        '{ROW_CFG, pcfb_pkg::REG_TARGET_SEL,   6'h03, 15'h0000, 6'd0,  6'd0,  1'b0, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h7FFF, 6'd40, 6'd13, 1'b1, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h7FFF, 6'd17, 6'd14, 1'b0, 15'h0000},
        '{ROW_CFG, pcfb_pkg::REG_SPEED_MASK,   6'h01, 15'h0000, 6'd0,  6'd0,  1'b0, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h7FFF, 6'd8,  6'd15, 1'b1, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h1CE7, 6'd3,  6'd16, 1'b0, 15'h0000},
        '{ROW_CFG, pcfb_pkg::REG_SPEED_MASK,   6'h08, 15'h0000, 6'd0,  6'd0,  1'b0, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h6318, 6'd20, 6'd17, 1'b0, 15'h0000},
        '{ROW_CFG, pcfb_pkg::REG_SPEED_MASK,   6'h07, 15'h0000, 6'd0,  6'd0,  1'b0, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h7FFF, 6'd16, 6'd18, 1'b1, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h0421, 6'd7,  6'd19, 1'b0, 15'h0000},
        '{ROW_CFG, pcfb_pkg::REG_SPEED_MASK,   6'h02, 15'h0000, 6'd0,  6'd0,  1'b0, 15'h0000},
        '{ROW_PIX, pcfb_pkg::REG_TARGET_SEL,   6'h00, 15'h7C00, 6'd12, 6'd20, 1'b0, 15'h0000}
    };

    palette_color_fade_blend #(
        .PALETTE_ENTRIES(PAL_ENTRIES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int ease_weight(logic [pcfb_pkg::IDX_W-1:0] idx);
        int i;
        i = idx;
        if (fade_cfg.speed_mask <= 6'd1) begin
            return ease8_tbl[(i > 8) ? 8 : i];
        end
        if (fade_cfg.speed_mask <= 6'd7) begin
            return ease16_tbl[(i > 16) ? 16 : i];
        end
        return (i > 32) ? 32 : i;
    endfunction

    function automatic logic [pcfb_pkg::CHAN_W-1:0] mix_chan(int c, int t, int w);
        int acc;
        acc = (c * (int'(pcfb_pkg::FULL_WEIGHT) - w) + t * w) >> 5;
        return acc[pcfb_pkg::CHAN_W-1:0];
    endfunction

    function automatic pcfb_pkg::t_pix_out fade_expect(pcfb_pkg::t_pix_in pix);
        int                          w;
        int                          wrb;
        int                          wg;
        int                          full_w;
        int                          hue_w;
        logic [pcfb_pkg::CHAN_W-1:0] tr;
        logic [pcfb_pkg::CHAN_W-1:0] tg;
        logic [pcfb_pkg::CHAN_W-1:0] tb;
        pcfb_pkg::t_pix_out          res;
        full_w = int'(pcfb_pkg::FULL_WEIGHT);
        w = ease_weight(pix.fade_index);
        hue_w = w + int'(pcfb_pkg::HUE_OFFSET);
        case (fade_cfg.target_sel)
            pcfb_pkg::STYLE_WHITE: begin
                tr = pcfb_pkg::CHAN_MAX;
                tg = pcfb_pkg::CHAN_MAX;
                tb = pcfb_pkg::CHAN_MAX;
            end
            pcfb_pkg::STYLE_CUSTOM: begin
                tr = fade_cfg.target_red;
                tg = fade_cfg.target_green;
                tb = fade_cfg.target_blue;
            end
            default: begin
                tr = '0;
                tg = '0;
                tb = '0;
            end
        endcase
        res.entry_out = pcfb_pkg::ENTRY_W'(int'(pix.entry_index) % PAL_ENTRIES);
        if (w == 0) begin
            res.faded_color = pix.color_in;
        end else if (w >= full_w) begin
            res.faded_color = {tb, tg, tr};
        end else begin
            wrb = w;
            wg = w;
            if (fade_cfg.target_sel == pcfb_pkg::STYLE_WHITE) begin
                wrb = (hue_w > full_w) ? full_w : hue_w;
            end else if (fade_cfg.target_sel == pcfb_pkg::STYLE_BLACK) begin
                wg = (hue_w > full_w) ? full_w : hue_w;
            end
            res.faded_color = {mix_chan(pix.color_in[14:10], tb, wrb),
                               mix_chan(pix.color_in[9:5], tg, wg),
                               mix_chan(pix.color_in[4:0], tr, wrb)};
        end
        return res;
    endfunction

    function automatic void latch_setting(logic [pcfb_pkg::CFG_IDX_W-1:0] idx,
                                          logic [pcfb_pkg::CFG_DAT_W-1:0] val);
        case (idx)
            pcfb_pkg::REG_TARGET_SEL:   fade_cfg.target_sel = pcfb_pkg::t_style'(val[1:0]);
            pcfb_pkg::REG_TARGET_RED:   fade_cfg.target_red = val[pcfb_pkg::CHAN_W-1:0];
            pcfb_pkg::REG_TARGET_GREEN: fade_cfg.target_green = val[pcfb_pkg::CHAN_W-1:0];
            pcfb_pkg::REG_TARGET_BLUE:  fade_cfg.target_blue = val[pcfb_pkg::CHAN_W-1:0];
            pcfb_pkg::REG_SPEED_MASK:   fade_cfg.speed_mask = val;
            default: ;
        endcase
    endfunction

    function automatic pcfb_pkg::t_pix_in random_pixel();
        pcfb_pkg::t_pix_in pix;
        int                pick;
        pick = $urandom_range(0, 9);
        pix.color_in = pcfb_pkg::COLOR_W'($urandom);
        if (pick == 0) begin
            pix.color_in = '0;
        end else if (pick == 1) begin
            pix.color_in = '1;
        end
        pix.fade_index = (pick < 8) ? pcfb_pkg::IDX_W'($urandom_range(0, 32))
                                    : pcfb_pkg::IDX_W'($urandom_range(33, 63));
        pix.entry_index = pcfb_pkg::ENTRY_W'($urandom);
        return pix;
    endfunction

    // drain all results, then write one register
    task automatic write_reg(input logic [pcfb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pcfb_pkg::CFG_DAT_W-1:0] val);
        i_in_valid <= 1'b0;
        while (fade_q.size() != 0) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        latch_setting(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_beat(input pcfb_pkg::t_pix_in pix, input logic known,
                             input logic [pcfb_pkg::COLOR_W-1:0] known_color);
        pcfb_pkg::t_pix_out want;
        want = fade_expect(pix);
        if (known) begin
            want.faded_color = known_color;
        end
        i_in_valid <= 1'b1;
        i_in_data <= pix;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        fade_q.push_back(want);
    endtask

    initial begin : rx_stall_pattern
        int mode;
        int span;
        int hold_left;
        mode = 0;
        span = 0;
        hold_left = 0;
        forever begin
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 120);
            end
            if (hold_req && hold_left == 0) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= span[2];
                endcase
            end
            span--;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (fade_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, o_out_data);
                err_count++;
            end else begin
                want_out = fade_q.pop_front();
                if (o_out_data.faded_color !== want_out.faded_color) begin
                    $display("%0t: faded_color expected %h actual %h (entry %0d)",
                             $time, want_out.faded_color, o_out_data.faded_color,
                             want_out.entry_out);
                    err_count++;
                end
                if (o_out_data.entry_out !== want_out.entry_out) begin
                    $display("%0t: entry_out expected %0d actual %0d",
                             $time, want_out.entry_out, o_out_data.entry_out);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int                p;
        int                remaining;
        int                burst;
        int                gap;
        logic [5:0]        speed;
        logic [5:0]        tgt;
        pcfb_pkg::t_pix_in pix;
        fade_cfg.target_sel = pcfb_pkg::STYLE_WHITE;
        fade_cfg.target_red = '0;
        fade_cfg.target_green = '0;
        fade_cfg.target_blue = '0;
        fade_cfg.speed_mask = 6'd3;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].is_cfg == ROW_CFG) begin
                write_reg(dir_table[r].reg_idx, dir_table[r].reg_val);
            end else begin
                pix.color_in = dir_table[r].color;
                pix.fade_index = dir_table[r].fidx;
                pix.entry_index = dir_table[r].entry;
                push_beat(pix, dir_table[r].known, dir_table[r].known_color);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0:       speed = 6'd0;
                1:       speed = 6'd63;
                2:       speed = 6'd1;
                3:       speed = 6'd8;
                4:       speed = 6'd7;
                5:       speed = 6'd2;
                default: speed = 6'($urandom);
            endcase
            write_reg(pcfb_pkg::REG_TARGET_SEL, {4'($urandom), 2'(p % 4)});
            write_reg(pcfb_pkg::REG_SPEED_MASK, speed);
            for (int c = 0; c < 3; c++) begin
                tgt = 6'($urandom);
                if (p == 2) begin
                    tgt[4:0] = '1;
                end else if (p == 6) begin
                    tgt[4:0] = '0;
                end
                case (c)
                    0:       write_reg(pcfb_pkg::REG_TARGET_RED, tgt);
                    1:       write_reg(pcfb_pkg::REG_TARGET_GREEN, tgt);
                    default: write_reg(pcfb_pkg::REG_TARGET_BLUE, tgt);
                endcase
            end
            if ($urandom_range(0, 1)) begin
                write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 6'($urandom));
            end

            remaining = PHASE_BEATS;
            if (p == 1) begin
                hold_req = 1'b1;
            end
            while (remaining > 0) begin
                burst = $urandom_range(1, 40);
                if (p == 1 && remaining == PHASE_BEATS) begin
                    burst = 2 * HOLD_CYCLES;
                end
                if (burst > remaining) begin
                    burst = remaining;
                end
                for (int k = 0; k < burst; k++) begin
                    push_beat(random_pixel(), 1'b0, '0);
                end
                remaining -= burst;
                gap = (p == 3) ? 0 : $urandom_range(0, 10);
                if (gap > 0 && remaining > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (fade_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
